>>> rtl/lkvc_pkg.sv
package lkvc_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam int unsigned S_DATA_W = KEY_W + VAL_W;
  localparam int unsigned S_USER_W = 1;
  localparam int unsigned M_DATA_W = VAL_W + KEY_W;
  localparam int unsigned M_USER_W = 2;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_e;

  typedef struct packed {
    logic valid;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> rtl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement, built as a row of
// MAX_ENTRIES cells kept in recency order: cell 0 holds the most recent entry and the valid
// entries fill the row from cell 0 up. Every word on the input (tuser: func; tdata: key, then
// value) is compared against all cells in the cycle it is accepted, the row shifts by one cell
// to bring the touched or inserted entry to the front, and the result word appears on the
// output register in the next cycle. One word is taken per clock; the output register is the
// only stage, so the input stalls only while a finished result waits to be taken. The capacity
// register resets to 16, a value of 0 acts as 1 and a value above MAX_ENTRIES acts as
// MAX_ENTRIES; when the capacity is lowered below the fill level, each put that misses evicts
// one entry. The cache is empty right after reset with no clearing pass.
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lkvc_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: key, value.
  input  logic [lkvc_pkg::S_DATA_W-1:0]       s_axis_tdata,
  // Fields from bit 0: func.
  input  logic [lkvc_pkg::S_USER_W-1:0]       s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: read_value, evicted_key.
  output logic [lkvc_pkg::M_DATA_W-1:0]       m_axis_tdata,
  // Fields from bit 0: found, evicted.
  output logic [lkvc_pkg::M_USER_W-1:0]       m_axis_tuser
);

  localparam int unsigned KEY_W = lkvc_pkg::KEY_W;
  localparam int unsigned VAL_W = lkvc_pkg::VAL_W;
  localparam int unsigned CFG_W = lkvc_pkg::CFG_W;
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  logic [CFG_W-1:0] cap_d, cap_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic             m_valid_d, m_valid_q;
  logic             found_d, found_q;
  logic             evicted_d, evicted_q;
  logic [VAL_W-1:0] read_value_d, read_value_q;
  logic [KEY_W-1:0] evicted_key_d, evicted_key_q;

  lkvc_pkg::func_e  func;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_value;
  logic             accept;

  lkvc_pkg::cell_ctrl_t ctrl [MAX_ENTRIES];
  logic [KEY_W-1:0] cell_key   [MAX_ENTRIES];
  logic [VAL_W-1:0] cell_value [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] is_last;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [VAL_W-1:0] hit_value;
  logic [KEY_W-1:0] last_key;
  logic [CMP_W-1:0] cap_raw, cap_eff;
  logic             full;
  logic             evict;
  logic             insert;
  logic             update;
  logic [IDX_W-1:0] limit;
  logic [KEY_W-1:0] head_key;
  logic [VAL_W-1:0] head_value;

  assign func     = lkvc_pkg::func_e'(s_axis_tuser[0]);
  assign in_key   = s_axis_tdata[KEY_W-1:0];
  assign in_value = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0] left_key;
    logic [VAL_W-1:0] left_value;

    if (i == 0) begin : g_head
      assign left_key   = head_key;
      assign left_value = head_value;
    end else begin : g_body
      assign left_key   = cell_key[i-1];
      assign left_value = cell_value[i-1];
    end

    assign ctrl[i].valid = (CNT_W'(i) < count_q);
    assign ctrl[i].shift = update && (IDX_W'(i) <= limit);
    assign is_last[i]    = (CNT_W'(i + 1) == count_q);

    lkvc_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl[i]),
      .cmp_key_i   (in_key),
      .left_key_i  (left_key),
      .left_value_i(left_value),
      .key_o       (cell_key[i]),
      .value_o     (cell_value[i]),
      .match_o     (match[i])
    );
  end

  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    last_key  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        hit_idx   = hit_idx | IDX_W'(i);
        hit_value = hit_value | cell_value[i];
      end
      if (is_last[i]) begin
        last_key = last_key | cell_key[i];
      end
    end
  end

  always_comb begin
    hit     = |match;
    cap_raw = CMP_W'(cap_q);
    if (cap_raw == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_raw > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_raw;
    end
    full   = (CMP_W'(count_q) + CMP_W'(1)) > cap_eff;
    evict  = (func == lkvc_pkg::FUNC_PUT) && !hit && full && (count_q != '0);
    insert = (func == lkvc_pkg::FUNC_PUT) && !hit && !evict;
    update = accept && (hit || (func == lkvc_pkg::FUNC_PUT));

    if (hit) begin
      limit = hit_idx;
    end else if (evict) begin
      limit = IDX_W'(count_q - CNT_W'(1));
    end else begin
      limit = IDX_W'(count_q);
    end

    head_key   = in_key;
    head_value = (hit && (func == lkvc_pkg::FUNC_GET)) ? hit_value : in_value;
  end

  always_comb begin
    cap_d         = cap_q;
    count_d       = count_q;
    m_valid_d     = m_valid_q;
    found_d       = found_q;
    evicted_d     = evicted_q;
    read_value_d  = read_value_q;
    evicted_key_d = evicted_key_q;

    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
    end
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (accept) begin
      m_valid_d     = 1'b1;
      found_d       = hit;
      evicted_d     = evict;
      evicted_key_d = evict ? last_key : '0;
      if (func == lkvc_pkg::FUNC_GET) begin
        read_value_d = hit ? hit_value : lkvc_pkg::MISS_VALUE;
      end else begin
        read_value_d = '0;
      end
      if (insert) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= lkvc_pkg::CFG_RESET;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      cap_q     <= cap_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q       <= found_d;
    evicted_q     <= evicted_d;
    read_value_q  <= read_value_d;
    evicted_key_q <= evicted_key_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {evicted_key_q, read_value_q};
  assign m_axis_tuser  = {evicted_q, found_q};

endmodule

>>> rtl/lkvc_cell.sv
module lkvc_cell (
  input  logic                       clk_i,
  input  lkvc_pkg::cell_ctrl_t       ctrl_i,
  input  logic [lkvc_pkg::KEY_W-1:0] cmp_key_i,
  input  logic [lkvc_pkg::KEY_W-1:0] left_key_i,
  input  logic [lkvc_pkg::VAL_W-1:0] left_value_i,
  output logic [lkvc_pkg::KEY_W-1:0] key_o,
  output logic [lkvc_pkg::VAL_W-1:0] value_o,
  output logic                       match_o
);

  logic [lkvc_pkg::KEY_W-1:0] key_d, key_q;
  logic [lkvc_pkg::VAL_W-1:0] value_d, value_q;

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.shift) begin
      key_d   = left_key_i;
      value_d = left_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = ctrl_i.valid && (key_q == cmp_key_i);

endmodule

>>> rtl/lkvc_checker.sv
module lkvc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lkvc_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic [lkvc_pkg::M_USER_W-1:0] m_axis_tuser
);

  // A stalled result word holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result word changed while stalled");

  // Every accepted word yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // No word is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // Only a put that missed can evict, and the evicted key is zero otherwise.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tuser[1] && !m_axis_tuser[0] && (m_axis_tdata[31:0] == '0)) ||
       (!m_axis_tuser[1] && (m_axis_tdata[63:32] == '0))))
    else $error("inconsistent eviction report");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

>>> dv/lru_key_value_cache_checker.sv
`timescale 1ns / 1ps

module lru_key_value_cache_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lkvc_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // Fields from bit 0: key, value.
  input  logic [lkvc_pkg::S_DATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: func.
  input  logic [lkvc_pkg::S_USER_W-1:0] s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: read_value, evicted_key.
  input  logic [lkvc_pkg::M_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: found, evicted.
  input  logic [lkvc_pkg::M_USER_W-1:0] m_axis_tuser,
  output int                            failures_o,
  output int                            pending_o
);

  localparam int unsigned KEY_W = lkvc_pkg::KEY_W;
  localparam int unsigned VAL_W = lkvc_pkg::VAL_W;
  localparam int unsigned CFG_W = lkvc_pkg::CFG_W;
  localparam int SLOTS = 16;

  typedef struct {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } cache_result_t;

  logic [KEY_W-1:0] slot_key[SLOTS];
  logic [VAL_W-1:0] slot_value[SLOTS];
  logic             slot_valid[SLOTS];
  int               slot_age[SLOTS];
  logic [CFG_W-1:0] capacity;

  cache_result_t results_due[$];
  cache_result_t due;
  cache_result_t got;

  // Applies one get or put to the shadow cache and returns the word it should produce.
  task automatic access_cache(input lkvc_pkg::func_e op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value, output cache_result_t res);
    int hit;
    int slot;
    int count;
    int limit;
    int age;
    hit = -1;
    slot = -1;
    count = 0;
    res.found = 1'b0;
    res.read_value = '0;
    res.evicted = 1'b0;
    res.evicted_key = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && slot_key[i] == key) hit = i;
      if (slot_valid[i]) count++;
    end
    if (hit >= 0) begin
      res.found = 1'b1;
      age = slot_age[hit];
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_age[i] < age) slot_age[i]++;
      end
      slot_age[hit] = 0;
      if (op == lkvc_pkg::FUNC_GET) res.read_value = slot_value[hit];
      else slot_value[hit] = value;
    end else if (op == lkvc_pkg::FUNC_GET) begin
      res.read_value = lkvc_pkg::MISS_VALUE;
    end else begin
      limit = int'(capacity);
      if (limit < 1) limit = 1;
      if (limit > SLOTS) limit = SLOTS;
      if (count + 1 > limit && count > 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && slot_age[i] == count - 1) slot = i;
        end
        if (slot >= 0) begin
          res.evicted = 1'b1;
          res.evicted_key = slot_key[slot];
          slot_valid[slot] = 1'b0;
        end
      end
      if (slot < 0) begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i]) slot_age[i]++;
        end
        slot_key[slot] = key;
        slot_value[slot] = value;
        slot_valid[slot] = 1'b1;
        slot_age[slot] = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i] = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_age[i] = 0;
      end
      capacity = lkvc_pkg::CFG_RESET;
      results_due.delete();
      failures_o = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.found = m_axis_tuser[0];
        got.evicted = m_axis_tuser[1];
        got.read_value = m_axis_tdata[VAL_W-1:0];
        got.evicted_key = m_axis_tdata[VAL_W +: KEY_W];
        if (results_due.size() == 0) begin
          $display("%0t: result word with nothing expected: found %0b read_value %h",
                   $time, got.found, got.read_value);
          $display("%0t: evicted %0b evicted_key %h",
                   $time, got.evicted, got.evicted_key);
          failures_o++;
        end else begin
          due = results_due.pop_front();
          if (got.found !== due.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, due.found, got.found);
            failures_o++;
          end
          if (got.read_value !== due.read_value) begin
            $display("%0t: read_value mismatch: expected %h, actual %h",
                     $time, due.read_value, got.read_value);
            failures_o++;
          end
          if (got.evicted !== due.evicted) begin
            $display("%0t: evicted mismatch: expected %0b, actual %0b",
                     $time, due.evicted, got.evicted);
            failures_o++;
          end
          if (got.evicted_key !== due.evicted_key) begin
            $display("%0t: evicted_key mismatch: expected %h, actual %h",
                     $time, due.evicted_key, got.evicted_key);
            failures_o++;
          end
        end
      end
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        access_cache(lkvc_pkg::func_e'(s_axis_tuser[0]), s_axis_tdata[KEY_W-1:0],
                     s_axis_tdata[KEY_W +: VAL_W], due);
        results_due.push_back(due);
      end
      pending_o = results_due.size();
    end
  end

endmodule

>>> dv/lru_key_value_cache_test.sv
`timescale 1ns / 1ps

module lru_key_value_cache_test;

  localparam int unsigned KEY_W    = lkvc_pkg::KEY_W;
  localparam int unsigned VAL_W    = lkvc_pkg::VAL_W;
  localparam int unsigned CFG_W    = lkvc_pkg::CFG_W;
  localparam int unsigned S_DATA_W = lkvc_pkg::S_DATA_W;
  localparam int unsigned S_USER_W = lkvc_pkg::S_USER_W;
  localparam int unsigned M_DATA_W = lkvc_pkg::M_DATA_W;
  localparam int unsigned M_USER_W = lkvc_pkg::M_USER_W;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic [S_USER_W-1:0]   s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [M_USER_W-1:0]   m_axis_tuser;

  int   failures;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic word_taken_q;

  lru_key_value_cache #(.MAX_ENTRIES(16)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  lru_key_value_cache_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .failures_o    (failures),
    .pending_o     (pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) word_taken_q <= 1'b0;
    else word_taken_q <= s_axis_tvalid && s_axis_tready;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(input lkvc_pkg::func_e op, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {value, key};
    s_axis_tuser = op;
    do @(negedge clk_i); while (!word_taken_q);
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] cap);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = cap;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] caps[10];
    logic [KEY_W-1:0] key_pool[24];
    logic [KEY_W-1:0] k;
    int               eff;
    int               pool_n;
    caps = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd2, 5'd17, 5'd7, 5'd30, 5'd0, 5'd0};
    caps[8] = CFG_W'($urandom_range(31));
    caps[9] = CFG_W'($urandom_range(31));
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_word(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(lkvc_pkg::FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(lkvc_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
    send_word(lkvc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    send_word(lkvc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_word(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send_word(lkvc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(lkvc_pkg::FUNC_GET, 32'h1234_5678, 32'h0000_0000);
    send_word(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
    send_word(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'hA5A5_A5A5);
    // The capacity drops below the fill level, so each put miss evicts only one entry.
    set_capacity(5'd2);
    send_word(lkvc_pkg::FUNC_PUT, 32'h0000_0001, 32'h0000_0001);
    send_word(lkvc_pkg::FUNC_PUT, 32'h0000_0002, 32'h0000_0002);
    send_word(lkvc_pkg::FUNC_GET, 32'h0000_0003, 32'h0000_0000);
    send_word(lkvc_pkg::FUNC_PUT, 32'h0000_0003, 32'h0000_0003);
    send_word(lkvc_pkg::FUNC_GET, 32'h0000_0002, 32'h0000_0000);
    set_capacity(5'd0);
    send_word(lkvc_pkg::FUNC_PUT, 32'h0000_0004, 32'h0000_0004);
    send_word(lkvc_pkg::FUNC_PUT, 32'h0000_0005, 32'h0000_0005);
    send_word(lkvc_pkg::FUNC_GET, 32'h0000_0005, 32'h0000_0000);

    for (int b = 0; b < 10; b++) begin
      set_capacity(caps[b]);
      send_idle_pct = (b % 4 == 1) ? 82 : (b % 4 == 3) ? 20 : 0;
      recv_stall_pct = (b % 4 == 2) ? 82 : (b % 4 == 3) ? 20 : 0;
      eff = (caps[b] == 0) ? 1 : (caps[b] > 16) ? 16 : int'(caps[b]);
      pool_n = eff + $urandom_range(1, 6);
      for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (int n = 0; n < 70; n++) begin
        k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(pool_n - 1)];
        send_word(lkvc_pkg::func_e'($urandom_range(1)), k, $urandom);
      end
    end

    drain();
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
